// ===== sv/slot_window_resend_scheduler_assert.svh =====
// Assertion macros shared by the scheduler RTL.
// Both macros expect i_clk and i_rst_n to be in scope.
`ifndef SLOT_WINDOW_RESEND_SCHEDULER_ASSERT_SVH
`define SLOT_WINDOW_RESEND_SCHEDULER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SWRS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SWRS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/swrs_pkg.sv =====
package swrs_pkg;

    // Field widths
    localparam int SLOT_W = 6;
    localparam int CNT_W  = 28;
    localparam int SEQ_W  = 27;
    localparam int WIN_W  = 7;
    localparam int ELEM_W = 32;

    // Elements carried by one message (power of two)
    localparam int ELEMENTS_PER_MESSAGE = 32;

    // Divider: total / window, one quotient bit per cycle
    localparam int DIV_STEPS = CNT_W;
    localparam int DIV_CNT_W = 5;

    // Operation codes
    localparam logic OP_START = 1'b0;
    localparam logic OP_RECV  = 1'b1;

    typedef struct packed {
        logic              operation;
        logic [ELEM_W-1:0] element_count;
        logic [SLOT_W-1:0] slot;
    } t_in_item;

    typedef struct packed {
        logic              send_valid;
        logic [SEQ_W-1:0]  seq_num;
        logic [SLOT_W-1:0] send_slot;
        logic              is_last;
        logic              all_done;
        logic              error;
    } t_out_item;

    // Divider request
    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] dividend;
        logic [WIN_W-1:0] divisor;
    } t_div_req;

    // Slot counter memory request
    typedef struct packed {
        logic              clr;
        logic              rd_en;
        logic [SLOT_W-1:0] rd_addr;
        logic              wr_en;
        logic [SLOT_W-1:0] wr_addr;
        logic [CNT_W-1:0]  wr_data;
    } t_mem_req;

endpackage

// ===== sv/swrs_div.sv =====
module swrs_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  swrs_pkg::t_div_req              i_req,
    output logic                            o_done,
    output logic [swrs_pkg::CNT_W-1:0]      o_quot,
    output logic [swrs_pkg::WIN_W-1:0]      o_rem
);

    localparam logic [swrs_pkg::DIV_CNT_W-1:0] LAST_STEP =
        swrs_pkg::DIV_CNT_W'(swrs_pkg::DIV_STEPS - 1);

    logic                              r_busy;
    logic                              r_done;
    logic [swrs_pkg::DIV_CNT_W-1:0]    r_cnt;
    logic [swrs_pkg::CNT_W-1:0]        r_quot;
    logic [swrs_pkg::WIN_W-1:0]        r_rem;
    logic [swrs_pkg::WIN_W-1:0]        r_dvs;

    logic [swrs_pkg::WIN_W:0]          rem_sh;
    logic [swrs_pkg::WIN_W:0]          diff;
    logic                              ge;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        rem_sh = {r_rem, r_quot[swrs_pkg::CNT_W-1]};
        diff   = rem_sh - {1'b0, r_dvs};
        ge     = rem_sh >= {1'b0, r_dvs};
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == LAST_STEP) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quot <= i_req.dividend;
            r_rem  <= '0;
            r_dvs  <= i_req.divisor;
        end else if (r_busy) begin
            r_quot <= {r_quot[swrs_pkg::CNT_W-2:0], ge};
            r_rem  <= ge ? diff[swrs_pkg::WIN_W-1:0] : rem_sh[swrs_pkg::WIN_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule

// ===== sv/swrs_mem.sv =====
module swrs_mem #(
    parameter int DEPTH = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  swrs_pkg::t_mem_req            i_req,
    output logic [swrs_pkg::CNT_W-1:0]    o_rd_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [swrs_pkg::CNT_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]           r_vld;
    logic [swrs_pkg::CNT_W-1:0] r_rd_data;
    logic                       r_rd_vld;

    // Counter storage, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr[AW-1:0]] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr[AW-1:0]];
        end
    end

    // Entry valid bits: an entry not written since the last clear reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_req.clr) begin
                r_vld <= '0;
            end else if (i_req.wr_en) begin
                r_vld[i_req.wr_addr[AW-1:0]] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_vld <= r_vld[i_req.rd_addr[AW-1:0]];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

// ===== sv/slot_window_resend_scheduler.sv =====
// Slot window resend scheduler.
// Input channel (i_in_valid / o_in_stall, payload i_in_item): a start item
// (operation 0) opens a tensor of element_count / 32 messages; a receive item
// (operation 1) reports the reply for one slot.
// Output channel (o_out_valid / i_out_stall, payload o_out_item): one result per
// receive, or a burst of min(window, messages) results per start (one if empty).
// Config channel (i_cfg_valid / o_cfg_ready, i_cfg_data): window size, which the
// user must write only while the block is idle; the block does not enforce it.
// Ready is always high. Timing: a receive is taken, its slot counter is read from
// the counter memory, the counter and next sequence number are worked out and
// registered, and the result is loaded into the output register; the next input
// is taken once the block is back in idle. An errored receive or an empty start
// goes straight to the output load. A start waits on the bit-serial quota divider
// (28 steps), and the burst then loads one result per cycle while the output is
// not stalled.
// The block takes one item at a time. A stalled output holds its result; the
// block waits to load the next one and keeps o_in_stall high until the item's
// last result is in the output register.
// Reset: window 32, no tensor active, all slot counters read as zero.
module slot_window_resend_scheduler #(
    parameter int MAX_SLOTS = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  swrs_pkg::t_in_item            i_in_item,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output swrs_pkg::t_out_item           o_out_item,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [swrs_pkg::WIN_W-1:0]    i_cfg_data
);

    `include "slot_window_resend_scheduler_assert.svh"

    localparam int CAP = (MAX_SLOTS < 64) ? MAX_SLOTS : 64;
    localparam logic [swrs_pkg::WIN_W-1:0] CAP_W = swrs_pkg::WIN_W'(CAP);
    localparam int PROD_W = swrs_pkg::CNT_W + swrs_pkg::WIN_W;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_DIV   = 5'b00010,
        S_BURST = 5'b00100,
        S_RD    = 5'b01000,
        S_EMIT  = 5'b10000
    } t_state;

    t_state                          r_state, n_state;
    logic [swrs_pkg::WIN_W-1:0]      r_window;
    logic                            r_active, n_active;
    logic [swrs_pkg::CNT_W-1:0]      r_rcvd, n_rcvd;
    logic [swrs_pkg::CNT_W-1:0]      r_total, n_total;
    logic [swrs_pkg::CNT_W-1:0]      r_quota, n_quota;
    logic [swrs_pkg::SLOT_W-1:0]     r_rem, n_rem;
    logic [swrs_pkg::WIN_W-1:0]      r_n, n_n;
    logic [swrs_pkg::WIN_W-1:0]      r_j, n_j;
    logic [swrs_pkg::SLOT_W-1:0]     r_slot, n_slot;
    swrs_pkg::t_out_item             r_res, n_res;
    logic                            r_add_seq, n_add_seq;
    logic [swrs_pkg::SEQ_W-1:0]      r_prod, n_prod;
    logic [swrs_pkg::CNT_W-1:0]      r_cnt1, n_cnt1;
    logic                            r_wr_pend, n_wr_pend;
    logic                            r_out_vld;
    swrs_pkg::t_out_item             r_out_item;

    logic                            in_acc;
    logic                            out_free;
    logic                            out_ld;
    swrs_pkg::t_out_item             out_data;
    logic [swrs_pkg::WIN_W-1:0]      w;
    logic [swrs_pkg::CNT_W-1:0]      total_in;
    logic                            rcv_bad;
    logic [swrs_pkg::CNT_W-1:0]      rcvd_inc;
    logic [swrs_pkg::CNT_W-1:0]      cnt_rd;
    logic                            owes;
    logic [swrs_pkg::CNT_W+swrs_pkg::WIN_W-1:0] prod;
    logic                            burst_last;

    swrs_pkg::t_div_req              div_req;
    logic                            div_done;
    logic [swrs_pkg::CNT_W-1:0]      div_quot;
    logic [swrs_pkg::WIN_W-1:0]      div_rem;
    swrs_pkg::t_mem_req              mem_req;

    swrs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quot  (div_quot),
        .o_rem   (div_rem)
    );

    swrs_mem #(
        .DEPTH (CAP)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (mem_req),
        .o_rd_data (cnt_rd)
    );

    // Handshakes
    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_vld || !i_out_stall;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out_item;

    // Effective window, clamped to 1..CAP
    always_comb begin
        if (r_window == '0) begin
            w = swrs_pkg::WIN_W'(1);
        end else if (r_window > CAP_W) begin
            w = CAP_W;
        end else begin
            w = r_window;
        end
    end

    // Datapath helpers
    assign total_in   = swrs_pkg::CNT_W'(i_in_item.element_count
                                          / swrs_pkg::ELEMENTS_PER_MESSAGE);
    assign rcv_bad    = !r_active || ({1'b0, i_in_item.slot} >= w);
    assign rcvd_inc   = r_rcvd + 1'b1;
    assign owes       = (cnt_rd < r_quota) || ((cnt_rd == r_quota) && (r_slot < r_rem));
    assign prod       = PROD_W'(w) * PROD_W'(cnt_rd);
    assign burst_last = ((r_j + 1'b1) == r_n);

    // Sequencer: one item at a time, read then modify and write back
    always_comb begin
        n_state   = r_state;
        n_active  = r_active;
        n_rcvd    = r_rcvd;
        n_total   = r_total;
        n_quota   = r_quota;
        n_rem     = r_rem;
        n_n       = r_n;
        n_j       = r_j;
        n_slot    = r_slot;
        n_res     = r_res;
        n_add_seq = r_add_seq;
        n_prod    = r_prod;
        n_cnt1    = r_cnt1;
        n_wr_pend = r_wr_pend;
        out_ld    = 1'b0;
        out_data  = '0;
        div_req   = '0;
        mem_req   = '0;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_slot = i_in_item.slot;
                    if (i_in_item.operation == swrs_pkg::OP_START) begin
                        n_total     = total_in;
                        n_rcvd      = '0;
                        n_active    = 1'b0;
                        mem_req.clr = 1'b1;
                        if (total_in == '0) begin
                            n_quota          = '0;
                            n_rem            = '0;
                            n_res            = '0;
                            n_res.is_last    = 1'b1;
                            n_res.all_done   = 1'b1;
                            n_add_seq        = 1'b0;
                            n_wr_pend        = 1'b0;
                            n_state          = S_EMIT;
                        end else begin
                            div_req.start    = 1'b1;
                            div_req.dividend = total_in;
                            div_req.divisor  = w;
                            n_state          = S_DIV;
                        end
                    end else if (rcv_bad) begin
                        n_res         = '0;
                        n_res.is_last = 1'b1;
                        n_res.error   = 1'b1;
                        n_add_seq     = 1'b0;
                        n_wr_pend     = 1'b0;
                        n_state       = S_EMIT;
                    end else begin
                        n_rcvd         = rcvd_inc;
                        n_res          = '0;
                        n_res.is_last  = 1'b1;
                        n_res.all_done = (rcvd_inc >= r_total);
                        if (rcvd_inc >= r_total) begin
                            n_active = 1'b0;
                        end
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = i_in_item.slot;
                        n_state         = S_RD;
                    end
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_quota  = div_quot;
                    n_rem    = swrs_pkg::SLOT_W'(div_rem);
                    n_active = 1'b1;
                    n_n      = (r_total < swrs_pkg::CNT_W'(w))
                               ? r_total[swrs_pkg::WIN_W-1:0] : w;
                    n_j      = '0;
                    n_state  = S_BURST;
                end
            end
            S_BURST: begin
                // first burst: slot j gets sequence number j, its counter set to one
                if (out_free) begin
                    out_ld              = 1'b1;
                    out_data.send_valid = 1'b1;
                    out_data.seq_num    = swrs_pkg::SEQ_W'(r_j);
                    out_data.send_slot  = r_j[swrs_pkg::SLOT_W-1:0];
                    out_data.is_last    = burst_last;
                    mem_req.wr_en       = 1'b1;
                    mem_req.wr_addr     = r_j[swrs_pkg::SLOT_W-1:0];
                    mem_req.wr_data     = swrs_pkg::CNT_W'(1);
                    n_j                 = r_j + 1'b1;
                    if (burst_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_RD: begin
                // counter is back from memory: decide and register the product
                n_add_seq        = owes;
                n_wr_pend        = owes;
                n_prod           = prod[swrs_pkg::SEQ_W-1:0];
                n_cnt1           = cnt_rd + 1'b1;
                n_res.send_valid = owes;
                n_res.send_slot  = owes ? r_slot : '0;
                n_state          = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    out_ld           = 1'b1;
                    out_data         = r_res;
                    out_data.seq_num = r_add_seq
                                       ? r_prod + swrs_pkg::SEQ_W'(r_slot) : '0;
                    mem_req.wr_en    = r_wr_pend;
                    mem_req.wr_addr  = r_slot;
                    mem_req.wr_data  = r_cnt1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control and tensor state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_window  <= swrs_pkg::WIN_W'(32);
            r_active  <= 1'b0;
            r_rcvd    <= '0;
            r_total   <= '0;
            r_quota   <= '0;
            r_rem     <= '0;
            r_wr_pend <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_active  <= n_active;
            r_rcvd    <= n_rcvd;
            r_total   <= n_total;
            r_quota   <= n_quota;
            r_rem     <= n_rem;
            r_wr_pend <= n_wr_pend;
            if (i_cfg_valid) begin
                r_window <= i_cfg_data;
            end
            if (out_ld) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Working registers and output register
    always_ff @(posedge i_clk) begin
        r_n       <= n_n;
        r_j       <= n_j;
        r_slot    <= n_slot;
        r_res     <= n_res;
        r_add_seq <= n_add_seq;
        r_prod    <= n_prod;
        r_cnt1    <= n_cnt1;
        if (out_ld) begin
            r_out_item <= out_data;
        end
    end

    `SWRS_ASSERT_NOW(a_burst_in_range, r_state == S_BURST, r_j < r_n, "burst index past burst length")
    `SWRS_ASSERT_NOW(a_mem_single_access, mem_req.wr_en, !mem_req.rd_en && !mem_req.clr, "memory write overlaps read or clear")
    `SWRS_ASSERT_NOW(a_active_has_total, r_active, r_total != '0, "active tensor with zero messages")
    `SWRS_ASSERT_NEXT(a_read_then_emit, r_state == S_RD, r_state == S_EMIT, "counter read not followed by write-back step")
    `SWRS_ASSERT_NOW(a_send_not_error, o_out_valid && o_out_item.send_valid, !o_out_item.error, "send ordered on an errored result")

endmodule
